@@ rtl/ptgb_pkg.sv @@
// Shared types and constants for the pulse train gate buffer.
// Used by the ring, the core and the top level; depends on nothing else.
package ptgb_pkg;

  localparam int PULSE_W = 16;
  localparam int COUNT_W = 8;
  localparam int TRAIN_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [PULSE_W-1:0] CUT_SHORT_LIMIT = 16'd65533;
  localparam logic [PULSE_W-1:0] CUT_SHORT_ADD = 16'd2;

  // operation codes
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // action codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_TOGGLE = 2'd1;
  localparam logic [1:0] ACT_KEEP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE = 2'd3;

  // reset values of the configuration registers
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd15;
  localparam logic [PULSE_W-1:0] FOOTER_RST = 16'd510;
  localparam logic [TRAIN_W-1:0] MIN_TRAIN_RST = 7'd22;
  localparam logic [PULSE_W-1:0] IDLE_RST = 16'd50000;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse_len;
    logic [PULSE_W-1:0] footer_len;
    logic [TRAIN_W-1:0] min_train_len;
    logic [PULSE_W-1:0] idle_len;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [PULSE_W-1:0] pulse_length;
    logic [PULSE_W-1:0] send_elapsed;
  } item_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [PULSE_W-1:0] duration;
  } result_t;

endpackage

@@ rtl/pulse_train_gate_buffer.sv @@
// Pulse train gate buffer: received pulse lengths are filtered, stored in a
// ring and released as whole trains; send events replay them as toggles or
// fall back to an idle pulse. One item is accepted every cycle while the
// output register is free or being taken. A result passes from the input
// register into the output register, which holds it until taken. The ring
// has a single write port that takes a stored length and a registered read
// port that has the entry at the read index ready before each send event.
// No clearing pass runs after reset; ring entries never written read as
// don't-care. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module pulse_train_gate_buffer #(
  parameter int RING_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ptgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptgb_pkg::PULSE_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [ptgb_pkg::PULSE_W-1:0] pulse_length,
  input  logic [ptgb_pkg::PULSE_W-1:0] send_elapsed,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   action,
  output logic [ptgb_pkg::PULSE_W-1:0] duration
);
  import ptgb_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t core_result;
  result_t out_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse_len <= MIN_PULSE_RST;
      cfg.footer_len <= FOOTER_RST;
      cfg.min_train_len <= MIN_TRAIN_RST;
      cfg.idle_len <= IDLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PULSE: cfg.min_pulse_len <= cfg_data;
        CFG_FOOTER:    cfg.footer_len <= cfg_data;
        CFG_MIN_TRAIN: cfg.min_train_len <= cfg_data[TRAIN_W-1:0];
        CFG_IDLE:      cfg.idle_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // move the input item on when the output register is free or being taken
  assign advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.operation <= operation;
      s1_item.pulse_length <= pulse_length;
      s1_item.send_elapsed <= send_elapsed;
    end
  end

  ptgb_core #(
    .RING_DEPTH (RING_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (s1_item),
    .result (core_result)
  );

  // output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign action = out_result.action;
  assign duration = out_result.duration;

endmodule

@@ rtl/ptgb_ring.sv @@
// Ring of stored pulse lengths: one write port and one registered read port.
// The read port prefetches the entry at the next read index; depends on ptgb_pkg.
module ptgb_ring #(
  parameter int DEPTH = 64,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [ptgb_pkg::PULSE_W-1:0] wr_data,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [ptgb_pkg::PULSE_W-1:0] rd_data
);
  import ptgb_pkg::*;

  logic [PULSE_W-1:0] mem [DEPTH];

  // store a length
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read the next entry; forward a write to the same entry in this cycle
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ptgb_core.sv @@
// Train gating and replay state: indexes, train counter and sleep flag.
// Computes one result per item; depends on ptgb_pkg and ptgb_ring.
module ptgb_core #(
  parameter int RING_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  ptgb_pkg::cfg_t    cfg,
  input  logic              fire,
  input  ptgb_pkg::item_t   item,
  output ptgb_pkg::result_t result
);
  import ptgb_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  logic [IDX_W-1:0]   write_index, write_index_next;
  logic [IDX_W-1:0]   read_index, read_index_next;
  logic [IDX_W-1:0]   train_start_index, train_start_index_next;
  logic [COUNT_W-1:0] train_count, train_count_next;
  logic               sender_asleep, sender_asleep_next;

  logic               store;
  logic               footer;
  logic               release_train;
  logic               has_entry;
  logic [IDX_W-1:0]   write_inc;
  logic [IDX_W-1:0]   read_inc;
  logic [COUNT_W-1:0] count_inc;
  logic [PULSE_W-1:0] rd_data;

  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] i);
    step_index = (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  assign write_inc = step_index(write_index);
  assign read_inc = step_index(read_index);
  assign count_inc = (train_count == COUNT_MAX) ? train_count : train_count + 1'b1;
  assign store = fire && (item.operation == OP_RECV) &&
                 (item.pulse_length >= cfg.min_pulse_len);
  assign footer = item.pulse_length > cfg.footer_len;
  assign release_train = ({1'b0, train_count} + 9'd1) >= {2'b00, cfg.min_train_len};
  assign has_entry = read_index != train_start_index;

  // next state and result for the item in flight
  always_comb begin
    write_index_next = write_index;
    read_index_next = read_index;
    train_start_index_next = train_start_index;
    train_count_next = train_count;
    sender_asleep_next = sender_asleep;
    result.action = ACT_NONE;
    result.duration = '0;
    if (item.operation == OP_RECV) begin
      if (item.pulse_length >= cfg.min_pulse_len) begin
        write_index_next = write_inc;
        if (release_train) begin
          // release: wake a sleeping sender and, below the cut limit, cut its pulse short
          if (sender_asleep) begin
            sender_asleep_next = 1'b0;
            read_index_next = train_start_index;
            if (item.send_elapsed < CUT_SHORT_LIMIT) begin
              result.action = ACT_KEEP;
              result.duration = item.send_elapsed + CUT_SHORT_ADD;
            end
          end
          train_start_index_next = write_inc;
          train_count_next = footer ? '0 : count_inc;
        end else if (footer) begin
          // short train: rewind and drop it
          write_index_next = train_start_index;
          train_count_next = '0;
        end else begin
          train_count_next = count_inc;
        end
      end
    end else begin
      if (!sender_asleep) begin
        result.action = ACT_TOGGLE;
        if (has_entry) begin
          result.duration = rd_data;
          read_index_next = read_inc;
        end else begin
          result.duration = cfg.idle_len;
          sender_asleep_next = 1'b1;
        end
      end else begin
        result.action = ACT_KEEP;
        result.duration = cfg.idle_len;
      end
    end
  end

  // hold state until an item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index <= '0;
      train_start_index <= '0;
      train_count <= '0;
      sender_asleep <= 1'b0;
    end else if (fire) begin
      write_index <= write_index_next;
      read_index <= read_index_next;
      train_start_index <= train_start_index_next;
      train_count <= train_count_next;
      sender_asleep <= sender_asleep_next;
    end
  end

  // ring of lengths, prefetching at the read index of the next cycle
  ptgb_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (write_index),
    .wr_data (item.pulse_length),
    .rd_addr (fire ? read_index_next : read_index),
    .rd_data (rd_data)
  );

  a_asleep_stays: assert property (@(posedge clk) disable iff (rst)
    fire && (item.operation == OP_SEND) && sender_asleep |=> sender_asleep)
    else $error("sender woke on a send event");

  a_wake_rewinds: assert property (@(posedge clk) disable iff (rst)
    store && release_train && sender_asleep
    |=> !sender_asleep && (read_index == $past(train_start_index)))
    else $error("release did not wake sender at train start");

  a_replay_advances: assert property (@(posedge clk) disable iff (rst)
    fire && (item.operation == OP_SEND) && !sender_asleep && has_entry
    |=> read_index == $past(read_inc))
    else $error("read index did not advance on replay");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    fire && (result.action == ACT_NONE) |-> result.duration == '0)
    else $error("no-change result carries a duration");

endmodule

@@ test/tb_pulse_train_gate_buffer.sv @@
// Self-checking testbench for pulse_train_gate_buffer: a directed start, then
// random pulse trains under several register settings and handshake pressures.
// Depends on ptgb_pkg and the pulse_train_gate_buffer RTL only.
module tb_pulse_train_gate_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import ptgb_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int PULSE_MAX = 65535;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_PULSE;
  logic [PULSE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_RECV;
  logic [PULSE_W-1:0] pulse_length = '0;
  logic [PULSE_W-1:0] send_elapsed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] action;
  logic [PULSE_W-1:0] duration;

  pulse_train_gate_buffer #(
    .RING_DEPTH(RING_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .pulse_length(pulse_length),
    .send_elapsed(send_elapsed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .action(action),
    .duration(duration)
  );

  // Predictor state: the gate's registers and ring as the block should hold them
  cfg_t gate_cfg = '{MIN_PULSE_RST, FOOTER_RST, MIN_TRAIN_RST, IDLE_RST};
  logic [PULSE_W-1:0] model_lengths [RING_DEPTH];
  logic [IDX_W-1:0] wr_ptr = '0;
  logic [IDX_W-1:0] rd_ptr = '0;
  logic [IDX_W-1:0] train_start = '0;
  logic [COUNT_W-1:0] train_count = '0;
  logic sender_asleep = 1'b0;

  item_t pending_items[$];
  result_t expected_results[$];
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  // Advance the gate by one item and return the result it should produce
  function automatic result_t gate_step(item_t it);
    result_t r;
    logic is_footer;
    r.action = ACT_NONE;
    r.duration = '0;
    if (it.operation == OP_RECV) begin
      if (it.pulse_length >= gate_cfg.min_pulse_len) begin
        is_footer = it.pulse_length > gate_cfg.footer_len;
        model_lengths[wr_ptr] = it.pulse_length;
        wr_ptr = wr_ptr + 1'b1;
        if (int'(train_count) + 1 >= int'(gate_cfg.min_train_len)) begin
          // release: wake a sleeping sender and, below the cut limit, cut its pulse short
          if (sender_asleep) begin
            sender_asleep = 1'b0;
            rd_ptr = train_start;
            if (it.send_elapsed < CUT_SHORT_LIMIT) begin
              r.action = ACT_KEEP;
              r.duration = it.send_elapsed + CUT_SHORT_ADD;
            end
          end
          train_start = wr_ptr;
          if (is_footer) begin
            train_count = '0;
          end else if (train_count != COUNT_MAX) begin
            train_count = train_count + 1'b1;
          end
        end else if (is_footer) begin
          // short train: drop it
          wr_ptr = train_start;
          train_count = '0;
        end else if (train_count != COUNT_MAX) begin
          train_count = train_count + 1'b1;
        end
      end
    end else if (!sender_asleep) begin
      r.action = ACT_TOGGLE;
      if (rd_ptr != train_start) begin
        r.duration = model_lengths[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
      end else begin
        r.duration = gate_cfg.idle_len;
        sender_asleep = 1'b1;
      end
    end else begin
      r.action = ACT_KEEP;
      r.duration = gate_cfg.idle_len;
    end
    return r;
  endfunction

  function automatic logic [PULSE_W-1:0] rand_elapsed();
    if ($urandom_range(0, 7) == 0)
      return PULSE_W'($urandom_range(PULSE_MAX - 4, PULSE_MAX));
    return PULSE_W'($urandom);
  endfunction

  function automatic logic [PULSE_W-1:0] data_pulse();
    if (gate_cfg.min_pulse_len <= gate_cfg.footer_len)
      return PULSE_W'($urandom_range(gate_cfg.min_pulse_len, gate_cfg.footer_len));
    return PULSE_W'($urandom_range(gate_cfg.min_pulse_len, PULSE_MAX));
  endfunction

  function automatic logic [PULSE_W-1:0] footer_pulse();
    int lo;
    lo = int'(gate_cfg.footer_len) + 1;
    if (lo < int'(gate_cfg.min_pulse_len)) lo = int'(gate_cfg.min_pulse_len);
    return PULSE_W'($urandom_range(lo, PULSE_MAX));
  endfunction

  task automatic push_recv(input logic [PULSE_W-1:0] len, input logic [PULSE_W-1:0] el);
    pending_items.push_back('{OP_RECV, len, el});
  endtask

  task automatic push_send(input logic [PULSE_W-1:0] el);
    pending_items.push_back('{OP_SEND, PULSE_W'($urandom), el});
  endtask

  // Hold until every queued item has gone in and every result has come out
  task automatic settle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(CFG_MIN_PULSE, c.min_pulse_len);
    write_reg(CFG_FOOTER, c.footer_len);
    write_reg(CFG_MIN_TRAIN, {{(PULSE_W - TRAIN_W){1'b0}}, c.min_train_len});
    write_reg(CFG_IDLE, c.idle_len);
    gate_cfg = c;
  endtask

  // Queue n counted items: mostly whole trains around the release threshold,
  // with send bursts, short noise pulses and fully random items mixed in
  task automatic add_random_items(input int n);
    int counted;
    int kind;
    int total;
    int lo;
    int k;
    item_t it;
    counted = 0;
    while (counted < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        lo = (gate_cfg.min_train_len > 3) ? int'(gate_cfg.min_train_len) - 3 : 1;
        total = $urandom_range(lo, int'(gate_cfg.min_train_len) + 3);
        for (k = 0; k < total; k++) begin
          if (k == total - 1 && gate_cfg.footer_len != PULSE_MAX[PULSE_W-1:0])
            push_recv(footer_pulse(), rand_elapsed());
          else
            push_recv(data_pulse(), rand_elapsed());
          counted++;
          if ($urandom_range(0, 2) == 0) begin
            push_send(rand_elapsed());
            counted++;
          end
        end
      end else if (kind < 80) begin
        total = $urandom_range(1, 8);
        for (k = 0; k < total; k++) push_send(rand_elapsed());
        counted += total;
      end else if (kind < 90) begin
        if (gate_cfg.min_pulse_len > 0)
          push_recv(PULSE_W'($urandom_range(0, int'(gate_cfg.min_pulse_len) - 1)),
                    rand_elapsed());
      end else begin
        it = '{1'($urandom_range(0, 1)), PULSE_W'($urandom), PULSE_W'($urandom)};
        pending_items.push_back(it);
        if (it.operation == OP_SEND || it.pulse_length >= gate_cfg.min_pulse_len) counted++;
      end
    end
  endtask

  task automatic run_phase(input cfg_t c, input int idle_pct, input int stall_pct,
                           input logic long_hold, input int n);
    settle();
    set_config(c);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) hold_req++;
    add_random_items(n);
    settle();
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Drive the input channel from the pending queue; predict on acceptance
  always @(posedge clk) begin
    item_t cur_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(gate_step(cur_item));
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          operation <= cur_item.operation;
          pulse_length <= cur_item.pulse_length;
          send_elapsed <= cur_item.send_elapsed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold on request
  always @(posedge clk) begin
    int hold_left;
    int hold_seen;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result %0d: unexpected, action %0d duration %0d",
                   results_seen, action, duration);
      end else begin
        want = expected_results.pop_front();
        if (action !== want.action || duration !== want.duration) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: action exp %0d got %0d, duration exp %0d got %0d",
                     results_seen, want.action, action, want.duration, duration);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    cfg_t rand_cfg;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed start with a two-pulse train threshold
    set_config('{16'd15, 16'd510, 7'd2, 16'd50000});
    push_send(16'd0);            // nothing released: idle pulse, sleep
    push_send(16'hFFFF);         // asleep: keep level
    push_recv(16'd0, 16'd0);     // below minimum: ignored
    push_recv(16'd14, 16'd0);
    push_recv(16'd15, 16'd0);
    push_recv(16'hFFFF, 16'hFFFF); // wake with long elapsed time: no cut
    push_send(16'd0);
    push_send(16'd0);
    push_send(16'd0);
    push_recv(16'd100, 16'd0);
    push_recv(16'd200, 16'd65532); // wake and cut short
    push_recv(16'd300, 16'd65533); // release while awake
    repeat (4) push_send(16'd0);
    push_recv(16'd510, 16'd0);   // equal to footer length: not a footer
    push_recv(16'd511, 16'd0);
    push_recv(16'd700, 16'd0);   // lone footer: train discarded
    repeat (3) push_send(16'd0);
    settle();

    run_phase('{MIN_PULSE_RST, FOOTER_RST, MIN_TRAIN_RST, IDLE_RST}, 0, 0, 1'b0, 120);
    run_phase('{16'd0, 16'hFFFF, 7'd1, 16'd0}, 54, 0, 1'b0, 100);
    run_phase('{16'hFFFF, 16'd0, 7'd64, 16'hFFFF}, 0, 54, 1'b0, 60);
    run_phase('{16'd100, 16'd1000, 7'd64, 16'd12345}, 17, 17, 1'b0, 150);
    run_phase('{16'd20, 16'd400, 7'd0, 16'd777}, 0, 0, 1'b1, 80);
    rand_cfg.min_pulse_len = PULSE_W'($urandom_range(0, 300));
    rand_cfg.footer_len = PULSE_W'($urandom_range(200, 5000));
    rand_cfg.min_train_len = TRAIN_W'($urandom_range(1, 30));
    rand_cfg.idle_len = PULSE_W'($urandom);
    run_phase(rand_cfg, 54, 54, 1'b0, 150);

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
